@@ sv/prot_pkg.sv @@
// Shared types and constants for the polygon/rectangle overlap test.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package prot_pkg;

   // Default coordinate width (Q16.16 fixed point).
   localparam int COORD_BITS_DEF = 32;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Control bits that travel with each edge job.
   typedef struct packed {
      logic edge_en;  // the job carries a real edge to test
      logic clear;    // a new polygon starts: clear the accumulated flags
      logic emit;     // give the result once this job is done
      logic check;    // corner-inside test is enabled
   } job_ctl_type;

   // Sequence of tests the back end runs on one edge.
   typedef enum logic [2:0] {
      STEP_LEFT   = 3'd0,
      STEP_RIGHT  = 3'd1,
      STEP_TOP    = 3'd2,
      STEP_BOTTOM = 3'd3,
      STEP_PARITY = 3'd4
   } step_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } back_state_type;

   // Width of one packed job: eight doubled coordinates plus control.
   function automatic int job_width(input int coord_bits);
      return 8 * (coord_bits + 2) + $bits(job_ctl_type);
   endfunction

endpackage

@@ sv/prot_front.sv @@
// Front end: accepts vertex beats, latches per-polygon state and turns each
// vertex into an edge job, plus a closing edge job for the last vertex. Depends on prot_pkg.
module prot_front #(
   parameter int COORD_BITS = prot_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [8*COORD_BITS-1:0]        req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           job_valid,
   input  logic                           job_ready,
   output logic [prot_pkg::job_width(COORD_BITS)-1:0] job_data
);
   import prot_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int CW = COORD_BITS + 2;

   logic signed [C-1:0] in_vx, in_vy, in_ox, in_oy, in_cx, in_cy;
   logic [C-2:0]        in_w, in_h;
   logic                in_chk;
   logic                accept;

   logic signed [C-1:0] start_x_ff, start_y_ff, prev_x_ff, prev_y_ff;
   logic signed [C-1:0] off_x_ff, off_y_ff, cx_ff, cy_ff;
   logic [C-2:0]        w_ff, h_ff;
   logic                check_ff;
   logic signed [C-1:0] pa_x_ff, pa_y_ff, pv_x_ff, pv_y_ff;
   logic                pfirst_ff, pend_a_ff, pend_b_ff;
   logic                pend_a_in, pend_b_in;

   logic signed [C-1:0]  ax, ay, bx, by;
   logic signed [CW-1:0] sum_x1, sum_y1, sum_x2, sum_y2;
   logic signed [CW-1:0] x1, y1, x2, y2, cx2, cy2, wd, hd, l, r, t, b;
   job_ctl_type          ctl;

   assign in_vx  = req_tdata[C-1:0];
   assign in_vy  = req_tdata[2*C-1:C];
   assign in_ox  = req_tdata[3*C-1:2*C];
   assign in_oy  = req_tdata[4*C-1:3*C];
   assign in_cx  = req_tdata[5*C-1:4*C];
   assign in_cy  = req_tdata[6*C-1:5*C];
   assign in_w   = req_tdata[7*C-2:6*C];
   assign in_h   = req_tdata[8*C-3:7*C-1];
   assign in_chk = req_tdata[8*C-2];

   assign req_tready = !pend_a_ff && !pend_b_ff;
   assign accept     = req_tvalid && req_tready;

   // Held polygon state and the pending vertex.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         off_x_ff   <= '0;
         off_y_ff   <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         w_ff       <= '0;
         h_ff       <= '0;
         check_ff   <= 1'b0;
      end else if (accept) begin
         prev_x_ff <= in_vx;
         prev_y_ff <= in_vy;
         if (req_tuser) begin
            start_x_ff <= in_vx;
            start_y_ff <= in_vy;
            off_x_ff   <= in_ox;
            off_y_ff   <= in_oy;
            cx_ff      <= in_cx;
            cy_ff      <= in_cy;
            w_ff       <= in_w;
            h_ff       <= in_h;
            check_ff   <= in_chk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pa_x_ff   <= prev_x_ff;
         pa_y_ff   <= prev_y_ff;
         pv_x_ff   <= in_vx;
         pv_y_ff   <= in_vy;
         pfirst_ff <= req_tuser;
      end
   end

   always_comb begin
      pend_a_in = pend_a_ff;
      pend_b_in = pend_b_ff;
      if (accept) begin
         pend_a_in = 1'b1;
         pend_b_in = req_tlast;
      end else if (job_ready && pend_a_ff) begin
         pend_a_in = 1'b0;
      end else if (job_ready && pend_b_ff) begin
         pend_b_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else begin
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
      end
   end

   // The first job is the edge into the vertex; the second closes the polygon.
   always_comb begin
      if (pend_a_ff) begin
         ax = pa_x_ff;
         ay = pa_y_ff;
         bx = pv_x_ff;
         by = pv_y_ff;
         ctl.edge_en = !pfirst_ff;
         ctl.clear   = pfirst_ff;
         ctl.emit    = 1'b0;
      end else begin
         ax = pv_x_ff;
         ay = pv_y_ff;
         bx = start_x_ff;
         by = start_y_ff;
         ctl.edge_en = 1'b1;
         ctl.clear   = 1'b0;
         ctl.emit    = 1'b1;
      end
      ctl.check = check_ff;
   end

   // Coordinates are doubled so that centre -/+ size/2 stays an integer.
   assign sum_x1 = CW'(ax) + CW'(off_x_ff);
   assign sum_y1 = CW'(ay) + CW'(off_y_ff);
   assign sum_x2 = CW'(bx) + CW'(off_x_ff);
   assign sum_y2 = CW'(by) + CW'(off_y_ff);
   assign x1  = {sum_x1[CW-2:0], 1'b0};
   assign y1  = {sum_y1[CW-2:0], 1'b0};
   assign x2  = {sum_x2[CW-2:0], 1'b0};
   assign y2  = {sum_y2[CW-2:0], 1'b0};
   assign cx2 = {cx_ff[C-1], cx_ff, 1'b0};
   assign cy2 = {cy_ff[C-1], cy_ff, 1'b0};
   assign wd  = {3'b000, w_ff};
   assign hd  = {3'b000, h_ff};
   assign l   = cx2 - wd;
   assign r   = cx2 + wd;
   assign t   = cy2 - hd;
   assign b   = cy2 + hd;

   assign job_valid = pend_a_ff || pend_b_ff;
   assign job_data  = {ctl, b, t, r, l, y2, x2, y1, x1};

endmodule

@@ sv/prot_queue.sv @@
// Short job queue between the front and back ends.
// Depends on prot_pkg for its depth.
module prot_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import prot_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;
   logic             push, pop;

   assign in_ready  = count_ff != NW'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + NW'(push) - NW'(pop);
      end
   end

endmodule

@@ sv/prot_back.sv @@
// Back end: runs the four side tests and the corner parity test of each edge
// through one shared set of six multipliers, and drives the result register.
// Depends on prot_pkg.
module prot_back #(
   parameter int COORD_BITS = prot_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_ready,
   input  logic [prot_pkg::job_width(COORD_BITS)-1:0] job_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata
);
   import prot_pkg::*;

   localparam int CW = COORD_BITS + 2;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int NM = 6;

   job_ctl_type          in_ctl, ctl_ff;
   logic signed [CW-1:0] in_c [8];
   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff, l_ff, r_ff, t_ff, b_ff;
   back_state_type       state_ff, state_in;
   step_type             step_ff, step_in;
   logic                 pop;

   logic signed [CW-1:0] x3, y3, x4, y4;
   logic signed [DW-1:0] ex, ey, sxd, syd, dx, dy;
   logic signed [DW-1:0] ma [NM];
   logic signed [DW-1:0] mb [NM];
   logic                 straddle, dpos;

   logic                 s1_vld_ff, s1_straddle_ff, s1_dpos_ff;
   step_type             s1_step_ff;
   logic signed [PW-1:0] prod_ff [NM];
   logic                 s2_vld_ff, s2_straddle_ff, s2_dpos_ff;
   step_type             s2_step_ff;
   logic signed [SW-1:0] den_ff, na_ff, nb_ff;

   logic                 side_hit, par_toggle;
   logic                 crossed_ff, parity_ff, crossed_in, parity_in;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff;
   logic                 corner, finish;

   assign in_ctl = job_data[8*CW +: $bits(job_ctl_type)];
   for (genvar i = 0; i < 8; i++) begin : g_unpack
      assign in_c[i] = job_data[i*CW +: CW];
   end

   assign job_ready = (state_ff == ST_IDLE) && (!in_ctl.emit || !rsp_valid_ff);
   assign pop       = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (pop) begin
         ctl_ff <= in_ctl;
         x1_ff  <= in_c[0];
         y1_ff  <= in_c[1];
         x2_ff  <= in_c[2];
         y2_ff  <= in_c[3];
         l_ff   <= in_c[4];
         r_ff   <= in_c[5];
         t_ff   <= in_c[6];
         b_ff   <= in_c[7];
      end
   end

   // Sequencer: one step issued per cycle, then wait for the pipeline to empty.
   assign finish = (state_ff == ST_DRAIN) && !s1_vld_ff && !s2_vld_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = STEP_LEFT;
            if (pop && in_ctl.edge_en) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (step_ff)
               STEP_LEFT:   step_in = STEP_RIGHT;
               STEP_RIGHT:  step_in = STEP_TOP;
               STEP_TOP:    step_in = STEP_BOTTOM;
               STEP_BOTTOM: step_in = STEP_PARITY;
               default: begin
                  step_in  = STEP_LEFT;
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_LEFT;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Operand selection for the shared multipliers.
   always_comb begin
      case (step_ff)
         STEP_LEFT: begin
            x3 = l_ff; y3 = t_ff; x4 = l_ff; y4 = b_ff;
         end
         STEP_RIGHT: begin
            x3 = r_ff; y3 = t_ff; x4 = r_ff; y4 = b_ff;
         end
         STEP_TOP: begin
            x3 = l_ff; y3 = t_ff; x4 = r_ff; y4 = t_ff;
         end
         default: begin
            x3 = l_ff; y3 = b_ff; x4 = r_ff; y4 = b_ff;
         end
      endcase
      ex  = DW'(x2_ff) - DW'(x1_ff);
      ey  = DW'(y2_ff) - DW'(y1_ff);
      sxd = DW'(x4) - DW'(x3);
      syd = DW'(y4) - DW'(y3);
      dx  = DW'(x1_ff) - DW'(x3);
      dy  = DW'(y1_ff) - DW'(y3);
      if (step_ff == STEP_PARITY) begin
         // Corner (l,t) against the edge: compare (l-x1)*(y2-y1) with (x2-x1)*(t-y1).
         ma[0] = DW'(l_ff) - DW'(x1_ff);  mb[0] = ey;
         ma[1] = ex;                      mb[1] = DW'(t_ff) - DW'(y1_ff);
         ma[2] = '0; mb[2] = '0;
         ma[3] = '0; mb[3] = '0;
         ma[4] = '0; mb[4] = '0;
         ma[5] = '0; mb[5] = '0;
      end else begin
         ma[0] = syd; mb[0] = ex;
         ma[1] = sxd; mb[1] = ey;
         ma[2] = sxd; mb[2] = dy;
         ma[3] = syd; mb[3] = dx;
         ma[4] = ex;  mb[4] = dy;
         ma[5] = ey;  mb[5] = dx;
      end
   end

   assign straddle = (y1_ff >= t_ff) != (y2_ff >= t_ff);
   assign dpos     = y2_ff > y1_ff;

   // Stage 1: products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= state_ff == ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff     <= step_ff;
      s1_straddle_ff <= straddle;
      s1_dpos_ff     <= dpos;
      for (int i = 0; i < NM; i++) begin
         prod_ff[i] <= ma[i] * mb[i];
      end
   end

   // Stage 2: denominator and numerators.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_step_ff     <= s1_step_ff;
      s2_straddle_ff <= s1_straddle_ff;
      s2_dpos_ff     <= s1_dpos_ff;
      den_ff         <= SW'(prod_ff[0]) - SW'(prod_ff[1]);
      na_ff          <= SW'(prod_ff[2]) - SW'(prod_ff[3]);
      nb_ff          <= SW'(prod_ff[4]) - SW'(prod_ff[5]);
   end

   // Decision: both parameters must lie in [0,1], taken without a division.
   always_comb begin
      if (den_ff == '0) begin
         side_hit = 1'b0;
      end else if (den_ff > 0) begin
         side_hit = (na_ff >= 0) && (na_ff <= den_ff) && (nb_ff >= 0) && (nb_ff <= den_ff);
      end else begin
         side_hit = (na_ff <= 0) && (na_ff >= den_ff) && (nb_ff <= 0) && (nb_ff >= den_ff);
      end
      par_toggle = s2_straddle_ff && (s2_dpos_ff ? (den_ff < 0) : (den_ff > 0));
   end

   always_comb begin
      crossed_in = crossed_ff;
      parity_in  = parity_ff;
      if (pop && in_ctl.clear) begin
         crossed_in = 1'b0;
         parity_in  = 1'b0;
      end else if (s2_vld_ff) begin
         if (s2_step_ff == STEP_PARITY) begin
            parity_in = parity_ff ^ par_toggle;
         end else begin
            crossed_in = crossed_ff | side_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crossed_ff <= 1'b0;
         parity_ff  <= 1'b0;
      end else begin
         crossed_ff <= crossed_in;
         parity_ff  <= parity_in;
      end
   end

   // Result register.
   assign corner = ctl_ff.check && parity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish && ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish && ctl_ff.emit) begin
         rsp_data_ff <= {5'b00000, corner, crossed_ff, crossed_ff | corner};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/polygon_rect_overlap_test_top.sv @@
// Top level of the polygon versus rectangle overlap test.
// Instantiates prot_front, prot_queue and prot_back; depends on prot_pkg.
//
// This block streams a polygon in one vertex per beat and tells whether it
// overlaps an axis-aligned rectangle. The beat flagged by req_tuser starts a
// polygon and also latches the rectangle (centre and size), the polygon
// offset and the inside-check enable; the beat flagged by req_tlast ends it,
// and exactly one result beat follows on the rsp side. Every vertex is
// shifted by the latched offset, each edge (the closing edge from the last
// vertex back to the first included) is tested against the four rectangle
// sides with an exact, division-free segment test, and the crossing parity
// of the rectangle's top-left corner is kept and, with the check enabled, reported.
// A vertex beat without the start flag continues the polygon held in the
// block, and the result flags are not cleared until the next start beat.
// All coordinates are signed fixed point, COORD_BITS wide.
// Flow: the front end hands the edge jobs of a beat to the queue one at a
// time and takes no new vertex until they are all queued.
// The back end owns the cost: each edge is loaded and then run through the
// shared set of six multipliers (four side tests and the parity test issued
// one per cycle), after which the pipeline empties and the flags settle.
// Each vertex but a polygon's first costs the back end one edge, and the last
// vertex one more, because it carries the closing edge too. A result leaves
// through an output register, and the two-entry job queue lets the front end
// keep taking vertices while that result waits.
module polygon_rect_overlap_test_top #(
   parameter int COORD_BITS = prot_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata, lowest bit up: vertex_x, vertex_y, offset_x, offset_y,
   // rect_center_x, rect_center_y, rect_width, rect_height, check_inside, pad
   input  logic [8*COORD_BITS-1:0] req_tdata,
   // tuser: first_vertex
   input  logic                    req_tuser,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tdata, lowest bit up: hit, edge_crossed, corner_inside, pad
   output logic [7:0]              rsp_tdata
);
   import prot_pkg::*;

   localparam int JW = job_width(COORD_BITS);

   logic          fj_valid, fj_ready, bj_valid, bj_ready;
   logic [JW-1:0] fj_data, bj_data;

   // The front end classifies beats into edge jobs.
   prot_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .job_valid  (fj_valid),
      .job_ready  (fj_ready),
      .job_data   (fj_data)
   );

   // The queue decouples the two halves so each can stall on its own.
   prot_queue #(.WIDTH(JW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fj_valid),
      .in_ready  (fj_ready),
      .in_data   (fj_data),
      .out_valid (bj_valid),
      .out_ready (bj_ready),
      .out_data  (bj_data)
   );

   // The back end runs the arithmetic and holds the result register.
   prot_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (bj_valid),
      .job_ready  (bj_ready),
      .job_data   (bj_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // The hit bit is always the OR of the two partial results.
   a_hit_is_or: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[1] | rsp_tdata[2])))
      else $error("hit does not match edge_crossed or corner_inside");

   // Every accepted beat queues an edge job, so the front end cannot take the
   // next beat in the following cycle; this is checked after a last vertex.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("front end took a beat while a closing edge was pending");

   // The front end holds a job until the queue has room to take it.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (fj_valid && !fj_ready) |=> fj_valid)
      else $error("front end dropped a job the queue had not taken");
`endif

endmodule

@@ bench/tb_polygon_rect_overlap_test_top.sv @@
// Self-checking testbench for polygon_rect_overlap_test_top.
// Streams polygons into the block, predicts every result beat with a scoreboard
// class and checks the outputs field by field; depends on prot_pkg and the RTL.
module tb_polygon_rect_overlap_test_top;

   typedef logic signed [127:0] wide_type;

   // One vertex beat, field by field.
   typedef struct {
      logic signed [31:0] vx, vy, ox, oy, cx, cy;
      logic [30:0]        w, h;
      logic               chk, first, last;
   } vertex_beat_type;

   // Scoreboard: keeps its own copy of the polygon state and a queue of the
   // overlap results that are still owed by the block.
   class overlap_scoreboard;
      longint start_x, start_y, prev_x, prev_y;
      longint ctr_x, ctr_y, size_w, size_h, off_x, off_y;
      bit     check_on, crossed, parity;
      logic [2:0] owed[$];   // {corner_inside, edge_crossed, hit}
      int     errors;

      function wide_type mul(longint a, longint b);
         return wide_type'(a) * wide_type'(b);
      endfunction

      // Closed segment test with numerators compared against the denominator.
      function bit seg_hit(longint x1, longint y1, longint x2, longint y2,
                           longint x3, longint y3, longint x4, longint y4);
         longint ex, ey, sx, sy, dx, dy;
         wide_type den, na, nb;
         ex = x2 - x1; ey = y2 - y1; sx = x4 - x3; sy = y4 - y3;
         dx = x1 - x3; dy = y1 - y3;
         den = mul(sy, ex) - mul(sx, ey);
         na  = mul(sx, dy) - mul(sy, dx);
         nb  = mul(ex, dy) - mul(ey, dx);
         if (den == 0) return 0;
         if (den > 0)
            return na >= 0 && na <= den && nb >= 0 && nb <= den;
         return na <= 0 && na >= den && nb <= 0 && nb >= den;
      endfunction

      // Tests one edge between raw vertices; coordinates are doubled so the
      // rectangle corners stay exact.
      function void test_edge(longint ax, longint ay, longint bx, longint by);
         longint x1, y1, x2, y2, l, r, t, b, dyv;
         wide_type lhs, rhs;
         x1 = 2 * (ax + off_x); y1 = 2 * (ay + off_y);
         x2 = 2 * (bx + off_x); y2 = 2 * (by + off_y);
         l = 2 * ctr_x - size_w; r = 2 * ctr_x + size_w;
         t = 2 * ctr_y - size_h; b = 2 * ctr_y + size_h;
         if (seg_hit(x1, y1, x2, y2, l, t, l, b) || seg_hit(x1, y1, x2, y2, r, t, r, b) ||
             seg_hit(x1, y1, x2, y2, l, t, r, t) || seg_hit(x1, y1, x2, y2, l, b, r, b))
            crossed = 1;
         if ((y1 >= t) == (y2 >= t)) return;
         dyv = y2 - y1;
         lhs = mul(l - x1, dyv);
         rhs = mul(x2 - x1, t - y1);
         if (dyv > 0 ? lhs < rhs : lhs > rhs) parity = !parity;
      endfunction

      function void note_vertex(vertex_beat_type v);
         bit corner;
         if (v.first) begin
            off_x = v.ox; off_y = v.oy; ctr_x = v.cx; ctr_y = v.cy;
            size_w = v.w; size_h = v.h; check_on = v.chk;
            start_x = v.vx; start_y = v.vy;
            crossed = 0; parity = 0;
         end else begin
            test_edge(prev_x, prev_y, v.vx, v.vy);
         end
         prev_x = v.vx; prev_y = v.vy;
         if (v.last) begin
            test_edge(v.vx, v.vy, start_x, start_y);
            corner = check_on && parity;
            owed.push_back({corner, crossed, crossed | corner});
         end
      endfunction

      function void check_result(logic [7:0] got);
         logic [2:0] want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %b", $time, got[2:0]);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got[0] !== want[0]) begin
            $display("%0t: hit mismatch, expected %b actual %b", $time, want[0], got[0]);
            errors++;
         end
         if (got[1] !== want[1]) begin
            $display("%0t: edge_crossed mismatch, expected %b actual %b",
                     $time, want[1], got[1]);
            errors++;
         end
         if (got[2] !== want[2]) begin
            $display("%0t: corner_inside mismatch, expected %b actual %b",
                     $time, want[2], got[2]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [7:0]   rsp_tdata;

   overlap_scoreboard sb = new();
   bit quiet = 0;     // set near the end: no idling on either side
   int idle_cycles = 0;

   polygon_rect_overlap_test_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The result side stalls in random bursts, and sometimes runs free for a
   // stretch; once the run is in its quiet tail it always accepts.
   initial begin
      int n;
      forever begin
         if (quiet || $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 30);
            repeat (n) begin
               @(negedge clock);
               rsp_tready <= 1;
            end
         end else begin
            n = $urandom_range(1, 14);
            repeat (n) begin
               @(negedge clock);
               rsp_tready <= 0;
            end
         end
      end
   end

   // Result beats are checked at the rising edge where they are taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // The watchdog counts cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) begin
         $display("tb_polygon_rect_overlap_test_top: FAIL");
         $finish;
      end
   end

   // Drives one vertex beat and waits for the block to take it. Valid stays
   // high into the next beat unless an idle burst follows.
   task automatic send_vertex(vertex_beat_type v);
      @(negedge clock);
      req_tdata  <= {1'b0, v.chk, v.h, v.w, v.cy, v.cx, v.oy, v.ox, v.vy, v.vx};
      req_tuser  <= v.first;
      req_tlast  <= v.last;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_vertex(v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
   endtask

   function automatic vertex_beat_type make_beat(longint vx, longint vy, longint ox,
                                                 longint oy, longint cx, longint cy,
                                                 longint w, longint h,
                                                 bit chk, bit first, bit last);
      vertex_beat_type v;
      v.vx = 32'(vx); v.vy = 32'(vy); v.ox = 32'(ox); v.oy = 32'(oy);
      v.cx = 32'(cx); v.cy = 32'(cy);
      v.w = 31'(w); v.h = 31'(h); v.chk = chk; v.first = first; v.last = last;
      return v;
   endfunction

   // Random coordinate near the origin, with an occasional full-range value.
   function automatic longint near_coord();
      if ($urandom_range(0, 19) == 0) return longint'(int'($urandom()));
      return (longint'($urandom_range(0, 400)) - 200) <<< 12;
   endfunction

   function automatic vertex_beat_type random_beat(bit first, bit last);
      vertex_beat_type v;
      v.vx = 32'(near_coord()); v.vy = 32'(near_coord());
      v.ox = 32'(near_coord() >>> 2); v.oy = 32'(near_coord() >>> 2);
      v.cx = 32'(near_coord()); v.cy = 32'(near_coord());
      v.w = 31'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300) << 12);
      v.h = 31'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300) << 12);
      v.chk = $urandom_range(0, 3) != 0;
      v.first = first; v.last = last;
      return v;
   endfunction

   localparam longint MAXC = 64'sd2147483647;
   localparam longint MINC = -64'sd2147483648;
   localparam longint ONE  = 64'sd65536;

   initial begin
      int n_items, nv;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Continuing a polygon right after reset: zero rectangle, start at 0,0.
      send_vertex(make_beat(5 * ONE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      // A single-vertex polygon gives neither a hit nor a crossing.
      send_vertex(make_beat(ONE, ONE, 0, 0, ONE, ONE, 4 * ONE, 4 * ONE, 1, 1, 1));
      // A square that encloses the rectangle: only the corner test fires.
      send_vertex(make_beat(-10 * ONE, -10 * ONE, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 1, 1, 0));
      send_vertex(make_beat(10 * ONE, -10 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_vertex(make_beat(10 * ONE, 10 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_vertex(make_beat(-10 * ONE, 10 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      // A continuation after the result keeps the old flags.
      send_vertex(make_beat(-11 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      // A diagonal across the square with the check off and a zero-width rectangle.
      send_vertex(make_beat(-10 * ONE, -10 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 1, 0));
      send_vertex(make_beat(10 * ONE, 10 * ONE, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      // An edge lying along a side is parallel to it but still hits the top and bottom sides at their ends.
      send_vertex(make_beat(-ONE, -4 * ONE, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 0, 1, 0));
      send_vertex(make_beat(-ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      // A shifted segment through the rectangle, crossing via the offset.
      send_vertex(make_beat(-3 * ONE, 0, 8 * ONE, ONE, 8 * ONE, ONE, ONE, ONE, 0, 1, 0));
      send_vertex(make_beat(3 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      // Extremes of every field.
      send_vertex(make_beat(MAXC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, 1, 1, 0));
      send_vertex(make_beat(MINC, MAXC, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      send_vertex(make_beat(MAXC, MAXC, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      send_vertex(make_beat(MINC, MINC, MINC, MAXC, MAXC, MINC, MAXC, 0, 1, 1, 0));
      send_vertex(make_beat(MAXC, MAXC, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_vertex(make_beat(-1, -1, -1, -1, -1, -1, MAXC, MAXC, 1, 1, 0));
      send_vertex(make_beat(MAXC, -1, -1, -1, -1, -1, 0, 0, 1, 0, 1));

      // Random polygons of one to eight vertices, with a little noise: beats
      // that continue a finished polygon and first flags in odd places.
      n_items = 0;
      while (n_items < 730) begin
         if (n_items > 360 && n_items < 380) begin
            // Hold off until the block has delivered every owed result; valid
            // drops first so the last beat is not taken twice.
            @(negedge clock);
            req_tvalid <= 0;
            while (sb.owed.size() != 0) @(posedge clock);
         end
         quiet = n_items > 640;
         nv = $urandom_range(1, 8);
         for (int k = 0; k < nv; k++) begin
            send_vertex(random_beat(k == 0 || $urandom_range(0, 49) == 0, k == nv - 1));
            n_items++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_vertex(random_beat(0, $urandom_range(0, 1)));
            n_items++;
         end
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_polygon_rect_overlap_test_top: PASS");
      else
         $display("tb_polygon_rect_overlap_test_top: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
sv/prot_pkg.sv
sv/prot_front.sv
sv/prot_queue.sv
sv/prot_back.sv
sv/polygon_rect_overlap_test_top.sv
bench/tb_polygon_rect_overlap_test_top.sv
